@@ hdl/estm_pkg.sv @@
// Package: shared types, constants and fixed-point helpers for the Euler transform pipeline.
package estm_pkg;

  localparam int unsigned CORDIC_STEPS = 20;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
  localparam logic signed [23:0] Q24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Q24_MIN = -24'sh800000;

  typedef logic signed [17:0] trig_t;   // Q16 value in [-65536, 65536]
  typedef logic signed [33:0] cval_t;   // CORDIC x/y in Q2.30 with growth
  typedef logic signed [33:0] zval_t;   // residual angle, 2^32 per turn

  typedef struct packed {
    cval_t      x;
    cval_t      y;
    zval_t      z;
    logic [1:0] quad;
  } cstate_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  typedef struct packed {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } side_t;

  typedef struct packed {
    logic signed [23:0] x0, x1, x2;
    logic signed [31:0] x3;
    logic signed [23:0] y0, y1, y2;
    logic signed [31:0] y3;
    logic signed [23:0] z0, z1, z2;
    logic signed [31:0] z3;
  } matrix_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Round a Q16*Q16 product back to Q16: add half, floor shift.
  function automatic logic signed [47:0] rnd16(input logic signed [47:0] p);
    logic signed [47:0] t;
    t = p + 48'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'(Q24_MAX)) r = Q24_MAX;
    else if (v < 48'(Q24_MIN)) r = Q24_MIN;
    else r = v[23:0];
    return r;
  endfunction

endpackage

@@ hdl/estm_cordic.sv @@
// One angle's sine and cosine: a pipelined 20-step CORDIC with quadrant fold.
module estm_cordic (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [15:0]          angle,
  output estm_pkg::sincos_t    sc
);

  estm_pkg::cstate_t st_r [estm_pkg::CORDIC_STEPS+1];
  estm_pkg::cstate_t st_nxt [estm_pkg::CORDIC_STEPS+1];
  estm_pkg::sincos_t sc_r, sc_nxt;

  always_comb begin
    st_nxt[0].x    = estm_pkg::CORDIC_X0;
    st_nxt[0].y    = '0;
    st_nxt[0].z    = {4'b0, angle[13:0], 16'b0};
    st_nxt[0].quad = angle[15:14];
  end

  // One rotation step per stage.
  for (genvar i = 0; i < estm_pkg::CORDIC_STEPS; i++) begin : g_step
    always_comb begin
      estm_pkg::cval_t dx, dy;
      estm_pkg::zval_t at;
      dx = st_r[i].y >>> i;
      dy = st_r[i].x >>> i;
      at = estm_pkg::zval_t'(estm_pkg::atan_turn(5'(i)));
      st_nxt[i+1].quad = st_r[i].quad;
      if (!st_r[i].z[33]) begin
        st_nxt[i+1].x = st_r[i].x - dx;
        st_nxt[i+1].y = st_r[i].y + dy;
        st_nxt[i+1].z = st_r[i].z - at;
      end else begin
        st_nxt[i+1].x = st_r[i].x + dx;
        st_nxt[i+1].y = st_r[i].y - dy;
        st_nxt[i+1].z = st_r[i].z + at;
      end
    end
  end

  always_comb begin
    estm_pkg::cval_t xr, yr;
    estm_pkg::trig_t c, s;
    estm_pkg::cstate_t f;
    f  = st_r[estm_pkg::CORDIC_STEPS];
    xr = (f.x + 34'sd8192) >>> 14;
    yr = (f.y + 34'sd8192) >>> 14;
    if (xr > 34'(estm_pkg::ONE_Q16)) c = estm_pkg::ONE_Q16;
    else if (xr < -34'(estm_pkg::ONE_Q16)) c = -estm_pkg::ONE_Q16;
    else c = xr[17:0];
    if (yr > 34'(estm_pkg::ONE_Q16)) s = estm_pkg::ONE_Q16;
    else if (yr < -34'(estm_pkg::ONE_Q16)) s = -estm_pkg::ONE_Q16;
    else s = yr[17:0];
    case (f.quad)
      2'd0: begin sc_nxt.s = s;  sc_nxt.c = c;  end
      2'd1: begin sc_nxt.s = c;  sc_nxt.c = -s; end
      2'd2: begin sc_nxt.s = -s; sc_nxt.c = -c; end
      default: begin sc_nxt.s = -c; sc_nxt.c = s; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= estm_pkg::CORDIC_STEPS; i++) st_r[i] <= st_nxt[i];
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule

@@ hdl/estm_matrix.sv @@
// Matrix assembly: rotation products, row scaling and saturation over four stages.
module estm_matrix (
  input  logic                clk,
  input  logic                adv,
  input  estm_pkg::sincos_t   yaw,
  input  estm_pkg::sincos_t   pitch,
  input  estm_pkg::sincos_t   roll,
  input  estm_pkg::side_t     side,
  output estm_pkg::matrix_t   mat
);

  typedef logic signed [47:0] w_t;

  // stage A: first-level products
  w_t sysp_r, cysp_r, cpcr_r, cpsr_r, sycp_r, cycp_r, nsp_r;
  w_t cy_r, sy_r, cr_r, sr_r;
  estm_pkg::side_t sa_r;
  // stage B: second-level products
  w_t b_ssc_r, b_cs_r, b_csc_r, b_ss_r, b_sss_r, b_cc_r, b_css_r, b_sc_r;
  w_t b_cpcr_r, b_cpsr_r, b_sycp_r, b_cycp_r, b_nsp_r;
  estm_pkg::side_t sb_r;
  // stage C: rotation entries
  w_t r_r [9];
  estm_pkg::side_t sc_r;
  estm_pkg::matrix_t mat_r;

  // 24x24 signed product, rounded back to Q16
  function automatic w_t m16(input logic signed [23:0] a, input logic signed [23:0] b);
    w_t p;
    p = 48'(a) * 48'(b);
    return estm_pkg::rnd16(p);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      sysp_r <= m16(24'(yaw.s), 24'(pitch.s));
      cysp_r <= m16(24'(yaw.c), 24'(pitch.s));
      cpcr_r <= m16(24'(pitch.c), 24'(roll.c));
      cpsr_r <= m16(24'(pitch.c), 24'(roll.s));
      sycp_r <= m16(24'(yaw.s), 24'(pitch.c));
      cycp_r <= m16(24'(yaw.c), 24'(pitch.c));
      nsp_r  <= -48'(pitch.s);
      cy_r <= 48'(yaw.c);
      sy_r <= 48'(yaw.s);
      cr_r <= 48'(roll.c);
      sr_r <= 48'(roll.s);
      sa_r <= side;

      b_ssc_r <= m16(24'(sysp_r), 24'(cr_r));
      b_cs_r  <= m16(24'(cy_r), 24'(sr_r));
      b_csc_r <= m16(24'(cysp_r), 24'(cr_r));
      b_ss_r  <= m16(24'(sy_r), 24'(sr_r));
      b_sss_r <= m16(24'(sysp_r), 24'(sr_r));
      b_cc_r  <= m16(24'(cy_r), 24'(cr_r));
      b_css_r <= m16(24'(cysp_r), 24'(sr_r));
      b_sc_r  <= m16(24'(sy_r), 24'(cr_r));
      b_cpcr_r <= cpcr_r;
      b_cpsr_r <= cpsr_r;
      b_sycp_r <= sycp_r;
      b_cycp_r <= cycp_r;
      b_nsp_r  <= nsp_r;
      sb_r <= sa_r;

      r_r[0] <= b_cpcr_r;
      r_r[1] <= b_ssc_r - b_cs_r;
      r_r[2] <= b_csc_r + b_ss_r;
      r_r[3] <= b_cpsr_r;
      r_r[4] <= b_sss_r + b_cc_r;
      r_r[5] <= b_css_r - b_sc_r;
      r_r[6] <= b_nsp_r;
      r_r[7] <= b_sycp_r;
      r_r[8] <= b_cycp_r;
      sc_r <= sb_r;

      // scale each row and clamp to Q8.16
      mat_r.x0 <= estm_pkg::sat24(m16(sc_r.sx, 24'(r_r[0])));
      mat_r.x1 <= estm_pkg::sat24(m16(sc_r.sx, 24'(r_r[1])));
      mat_r.x2 <= estm_pkg::sat24(m16(sc_r.sx, 24'(r_r[2])));
      mat_r.x3 <= sc_r.px;
      mat_r.y0 <= estm_pkg::sat24(m16(sc_r.sy, 24'(r_r[3])));
      mat_r.y1 <= estm_pkg::sat24(m16(sc_r.sy, 24'(r_r[4])));
      mat_r.y2 <= estm_pkg::sat24(m16(sc_r.sy, 24'(r_r[5])));
      mat_r.y3 <= sc_r.py;
      mat_r.z0 <= estm_pkg::sat24(m16(sc_r.sz, 24'(r_r[6])));
      mat_r.z1 <= estm_pkg::sat24(m16(sc_r.sz, 24'(r_r[7])));
      mat_r.z2 <= estm_pkg::sat24(m16(sc_r.sz, 24'(r_r[8])));
      mat_r.z3 <= sc_r.pz;
    end
  end

  assign mat = mat_r;

endmodule

@@ hdl/estm_side_delay.sv @@
// Delay line that carries scale and position alongside the CORDIC stages.
module estm_side_delay #(
  parameter int unsigned DEPTH = 22
) (
  input  logic            clk,
  input  logic            adv,
  input  estm_pkg::side_t din,
  output estm_pkg::side_t dout
);

  estm_pkg::side_t tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

@@ hdl/euler_scaled_transform_matrix_top.sv @@
// Top level: Z-Y-X Euler angles, scale and position to a 3x4 object-to-world matrix.
// Pipeline: 22 CORDIC stages (input register, 20 steps, quadrant fold), then 4 matrix
//   stages, the last of which is the output register.
// Throughput: one word per cycle; the whole pipeline freezes while out_stall holds
//   a full output register, so in_stall simply mirrors that condition.
// Reset: rst_n (synchronous, active low) clears the stage valid bits only.
module euler_scaled_transform_matrix_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_yaw_angle,
  input  logic [15:0]        in_pitch_angle,
  input  logic [15:0]        in_roll_angle,
  input  logic signed [23:0] in_scale_x,
  input  logic signed [23:0] in_scale_y,
  input  logic signed [23:0] in_scale_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_m_x0,
  output logic signed [23:0] out_m_x1,
  output logic signed [23:0] out_m_x2,
  output logic signed [31:0] out_m_x3,
  output logic signed [23:0] out_m_y0,
  output logic signed [23:0] out_m_y1,
  output logic signed [23:0] out_m_y2,
  output logic signed [31:0] out_m_y3,
  output logic signed [23:0] out_m_z0,
  output logic signed [23:0] out_m_z1,
  output logic signed [23:0] out_m_z2,
  output logic signed [31:0] out_m_z3
);

  // CORDIC: input register + 20 step stages + 1 fold stage. Matrix: 4 stages.
  localparam int unsigned CORDIC_LAT = estm_pkg::CORDIC_STEPS + 2;
  localparam int unsigned TOTAL_LAT  = CORDIC_LAT + 4;

  logic [TOTAL_LAT-1:0] vld_r;
  logic adv;

  // Advance everything unless the last stage holds a word the sink refuses.
  assign adv      = !(vld_r[TOTAL_LAT-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], in_valid};
    end
  end

  estm_pkg::sincos_t sc_yaw, sc_pitch, sc_roll;
  estm_pkg::side_t   side_in, side_dly;
  estm_pkg::matrix_t mat;

  estm_cordic u_cyaw   (.clk, .adv, .angle(in_yaw_angle),   .sc(sc_yaw));
  estm_cordic u_cpitch (.clk, .adv, .angle(in_pitch_angle), .sc(sc_pitch));
  estm_cordic u_croll  (.clk, .adv, .angle(in_roll_angle),  .sc(sc_roll));

  assign side_in = '{sx: in_scale_x, sy: in_scale_y, sz: in_scale_z,
                     px: in_pos_x, py: in_pos_y, pz: in_pos_z};

  // Hold scale and position in step with the CORDIC.
  estm_side_delay #(.DEPTH(CORDIC_LAT)) u_side (
    .clk, .adv, .din(side_in), .dout(side_dly)
  );

  estm_matrix u_mat (
    .clk, .adv, .yaw(sc_yaw), .pitch(sc_pitch), .roll(sc_roll),
    .side(side_dly), .mat(mat)
  );

  assign out_valid = vld_r[TOTAL_LAT-1];
  assign out_m_x0 = mat.x0;
  assign out_m_x1 = mat.x1;
  assign out_m_x2 = mat.x2;
  assign out_m_x3 = mat.x3;
  assign out_m_y0 = mat.y0;
  assign out_m_y1 = mat.y1;
  assign out_m_y2 = mat.y2;
  assign out_m_y3 = mat.y3;
  assign out_m_z0 = mat.z0;
  assign out_m_z1 = mat.z1;
  assign out_m_z2 = mat.z2;
  assign out_m_z3 = mat.z3;

endmodule

@@ hdl/estm_checker.sv @@
// Port-level checker for the Euler transform block, bound to the top level.
module estm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] out_m_x0,
  input logic signed [31:0] out_m_x3
);

  // Stall on input only while an output word waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting output word");

  // A waiting output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_m_x0) && $stable(out_m_x3)))
    else $error("stalled output word changed");

  // No output word right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A free-flowing block accepts input.
  a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

endmodule

bind euler_scaled_transform_matrix_top estm_checker u_estm_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_m_x0, .out_m_x3
);

@@ tb/tb_euler_scaled_transform_matrix_top.sv @@
// Testbench for the scaled Euler transform: random and corner words checked by a predictor.
module tb_euler_scaled_transform_matrix_top;

  typedef struct {
    logic [15:0] yaw, pitch, roll;
    logic signed [23:0] sx, sy, sz;
    logic signed [31:0] px, py, pz;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_yaw_angle = '0, in_pitch_angle = '0, in_roll_angle = '0;
  logic signed [23:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_m_x0, out_m_x1, out_m_x2, out_m_y0, out_m_y1, out_m_y2;
  logic signed [23:0] out_m_z0, out_m_z1, out_m_z2;
  logic signed [31:0] out_m_x3, out_m_y3, out_m_z3;

  euler_scaled_transform_matrix_top dut (.*);

  // Words waiting to be driven, and matrices waiting to come out.
  pose_t pending_poses[$];
  estm_pkg::matrix_t expected_mats[$];
  int n_sent = 0, n_checked = 0, n_mismatch = 0;
  int cycles = 0;
  bit hold_sender = 1'b0;
  bit long_stall_req = 1'b0;
  bit in_took = 1'b0;
  localparam int CYCLE_LIMIT = 400000;

  // Append a pose to the tail of the send queue.
  function automatic void queue_pose(pose_t p);
    pending_poses = {pending_poses, p};
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // Shift by floor, like an arithmetic right shift on a wide value.
  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return asr64(a * b + 32768, 16);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // CORDIC sine/cosine in Q16 for a 16-bit turn fraction.
  task automatic turn_sincos(input logic [15:0] ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy, s, c;
    logic [31:0] tbl[20] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
      32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
      32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F,
      32'h00000517};
    x = 652032874;
    y = 0;
    z = longint'(ang[13:0]) << 16;
    for (int i = 0; i < 20; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(tbl[i]);
      end else begin
        x += dx; y -= dy; z += longint'(tbl[i]);
      end
    end
    c = clip(asr64(x + 8192, 14), -65536, 65536);
    s = clip(asr64(y + 8192, 14), -65536, 65536);
    case (ang[15:14])
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  function automatic logic signed [23:0] scaled_entry(longint k, longint rot);
    return 24'(clip(qmul(k, rot), -8388608, 8388607));
  endfunction

  task automatic predict_matrix(input pose_t p, output estm_pkg::matrix_t m);
    longint sy, cy, sp, cp, sr, cr, sysp, cysp;
    turn_sincos(p.yaw, sy, cy);
    turn_sincos(p.pitch, sp, cp);
    turn_sincos(p.roll, sr, cr);
    sysp = qmul(sy, sp);
    cysp = qmul(cy, sp);
    m.x0 = scaled_entry(p.sx, qmul(cp, cr));
    m.x1 = scaled_entry(p.sx, qmul(sysp, cr) - qmul(cy, sr));
    m.x2 = scaled_entry(p.sx, qmul(cysp, cr) + qmul(sy, sr));
    m.x3 = p.px;
    m.y0 = scaled_entry(p.sy, qmul(cp, sr));
    m.y1 = scaled_entry(p.sy, qmul(sysp, sr) + qmul(cy, cr));
    m.y2 = scaled_entry(p.sy, qmul(cysp, sr) - qmul(sy, cr));
    m.y3 = p.py;
    m.z0 = scaled_entry(p.sz, -sp);
    m.z1 = scaled_entry(p.sz, qmul(sy, cp));
    m.z2 = scaled_entry(p.sz, qmul(cy, cp));
    m.z3 = p.pz;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present the next pose at the falling edge; hold it until it is taken.
  int drv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_poses.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          in_yaw_angle <= pending_poses[0].yaw;
          in_pitch_angle <= pending_poses[0].pitch;
          in_roll_angle <= pending_poses[0].roll;
          in_scale_x <= pending_poses[0].sx;
          in_scale_y <= pending_poses[0].sy;
          in_scale_z <= pending_poses[0].sz;
          in_pos_x <= pending_poses[0].px;
          in_pos_y <= pending_poses[0].py;
          in_pos_z <= pending_poses[0].pz;
          drv_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept: predict on every taken word and drop it from the queue.
  always @(posedge clk) begin
    pose_t p;
    estm_pkg::matrix_t m;
    cycles <= cycles + 1;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      p = pending_poses.pop_front();
      predict_matrix(p, m);
      expected_mats = {expected_mats, m};
      n_sent <= n_sent + 1;
    end
  end

  // Receiver stall: random gaps, plus one long hold-off on request.
  int rx_gap = 0;
  int long_left = 0;
  always @(negedge clk) begin
    if (long_stall_req && long_left == 0) begin
      long_left <= 300;
      long_stall_req <= 1'b0;
      out_stall <= 1'b1;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      out_stall <= (long_left > 1);
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_stall <= 1'b1;
    end else begin
      rx_gap <= gap_len();
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each taken matrix with the oldest prediction.
  always @(posedge clk) begin
    estm_pkg::matrix_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_m_x0, out_m_x1, out_m_x2, out_m_x3, out_m_y0, out_m_y1, out_m_y2,
              out_m_y3, out_m_z0, out_m_z1, out_m_z2, out_m_z3};
      if (expected_mats.size() == 0) begin
        n_mismatch <= n_mismatch + 1;
        if (n_mismatch < 10) $display("unexpected matrix word %h", got);
      end else begin
        want = expected_mats.pop_front();
        if (got !== want) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) begin
            $display("mismatch at word %0d", n_checked);
            $display("  exp x %h %h %h %h y %h %h %h %h z %h %h %h %h",
                     want.x0, want.x1, want.x2, want.x3, want.y0, want.y1,
                     want.y2, want.y3, want.z0, want.z1, want.z2, want.z3);
            $display("  got x %h %h %h %h y %h %h %h %h z %h %h %h %h",
                     got.x0, got.x1, got.x2, got.x3, got.y0, got.y1,
                     got.y2, got.y3, got.z0, got.z1, got.z2, got.z3);
          end
        end
        n_checked <= n_checked + 1;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic pose_t rand_pose();
    pose_t p;
    int pick;
    p.yaw = 16'($urandom); p.pitch = 16'($urandom); p.roll = 16'($urandom);
    // Mostly moderate scales; sometimes full range to reach saturation.
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      p.sx = 24'($signed($urandom_range(0, 262143)) - 131072);
      p.sy = 24'($signed($urandom_range(0, 262143)) - 131072);
      p.sz = 24'($signed($urandom_range(0, 262143)) - 131072);
    end else begin
      p.sx = 24'($urandom); p.sy = 24'($urandom); p.sz = 24'($urandom);
    end
    // Hit quadrant seams now and then.
    if (pick == 3) p.yaw = {p.yaw[15:14], 14'd0};
    if (pick == 4) p.pitch = {p.pitch[15:14], 14'h3FFF};
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    return p;
  endfunction

  function automatic pose_t mk(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic signed [23:0] k, logic signed [31:0] t);
    pose_t p;
    p.yaw = a; p.pitch = b; p.roll = c;
    p.sx = k; p.sy = k; p.sz = k;
    p.px = t; p.py = ~t; p.pz = t ^ 32'h5A5A_A5A5;
    return p;
  endfunction

  initial begin
    logic [15:0] quads[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                              16'h3FFF, 16'h7FFF, 16'hBFFF, 16'hFFFF};
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: quadrant boundaries, unit and extreme scales, extreme positions.
    for (int i = 0; i < 8; i++)
      queue_pose(mk(quads[i], quads[7 - i], quads[(i + 3) % 8],
                    24'sh010000, 32'sh7FFF_FFFF));
    queue_pose(mk(16'h0000, 16'h0000, 16'h0000, 24'sh7FFFFF, 32'sh8000_0000));
    queue_pose(mk(16'h2000, 16'h2000, 16'h2000, 24'sh7FFFFF, 32'sh0));
    queue_pose(mk(16'hE000, 16'h6000, 16'hA000, 24'sh800000, -32'sd1));
    queue_pose(mk(16'h1234, 16'h4000, 16'h5678, 24'sh000000, 32'sh0001_0000));
    queue_pose(mk(16'h4000, 16'hC000, 16'h8000, -24'sh010000, 32'sh0));
    queue_pose(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'sh000001, 32'sh0));
    queue_pose(mk(16'h5555, 16'hAAAA, 16'h5555, 24'shFFFFFF, 32'shAAAA_5555));
    queue_pose(mk(16'hAAAA, 16'h5555, 16'hAAAA, 24'sh555555, 32'sh5555_AAAA));

    // Drain fully, then hold off until every prediction is met.
    wait (pending_poses.size() == 0 && expected_mats.size() == 0);

    // Fill the pipe while the receiver holds off for a long stretch.
    long_stall_req = 1'b1;
    for (int i = 0; i < 150; i++) queue_pose(rand_pose());
    wait (pending_poses.size() == 0 && expected_mats.size() == 0);

    // Pause the sender midway until all results arrive, then continue.
    for (int i = 0; i < 150; i++) queue_pose(rand_pose());
    wait (pending_poses.size() <= 75);
    hold_sender = 1'b1;
    wait (expected_mats.size() == 0);
    hold_sender = 1'b0;
    wait (pending_poses.size() == 0);
    for (int i = 0; i < 134; i++) queue_pose(rand_pose());
    wait (pending_poses.size() == 0 && expected_mats.size() == 0);
    repeat (40) @(posedge clk);

    $display("Covered %0d words: quadrant seams, saturating scales, extreme positions,",
             n_sent);
    $display("random stalls on both sides, one long output hold-off and one drain pause.");
    if (n_mismatch == 0 && expected_mats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/estm_pkg.sv
hdl/estm_cordic.sv
hdl/estm_matrix.sv
hdl/estm_side_delay.sv
hdl/euler_scaled_transform_matrix_top.sv
hdl/estm_checker.sv
tb/tb_euler_scaled_transform_matrix_top.sv
